### rtl/bayer_superpixel_debayer_core_defines.svh
// assertion macros for the bayer superpixel debayer core
// used by the checker only; expects clk and rst in the scope of use
`ifndef BAYER_SUPERPIXEL_DEBAYER_CORE_DEFINES_SVH
`define BAYER_SUPERPIXEL_DEBAYER_CORE_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define BSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, ignored while in reset
`define BSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define BSD_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bsd_pkg.sv
// shared types and constants for the bayer superpixel debayer core
// no dependencies
package bsd_pkg;

  // default sizing
  localparam int MAX_ROW_WIDTH_DEF = 4096;
  localparam int SAMPLE_BITS_DEF   = 16;

  // fixed field widths
  localparam int RAW_SAMPLE_BITS = 16;
  localparam int COLOUR_BITS     = 16;
  localparam int GREEN_SUM_BITS  = 17;
  localparam int ROW_WIDTH_BITS  = 13;

  // configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 13;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CFA_PATTERN = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_WIDTH   = 1'd1;

  localparam int ROW_WIDTH_RESET = 4096;

  // bayer layouts, top-left first
  typedef enum logic [1:0] {
    PAT_RGGB = 2'd0,
    PAT_BGGR = 2'd1,
    PAT_GBRG = 2'd2,
    PAT_GRBG = 2'd3
  } cfa_pattern_t;

endpackage

### rtl/bsd_raw_if.sv
// raw sample stream: valid/ready handshake with the raw sample payload
// depends on bsd_pkg
interface bsd_raw_if;
  import bsd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [RAW_SAMPLE_BITS-1:0] raw_sample;
  logic                       frame_start;

  modport source (output valid, output raw_sample, output frame_start, input ready);
  modport sink   (input valid, input raw_sample, input frame_start, output ready);
endinterface

### rtl/bsd_rgb_if.sv
// rgb pixel stream: valid/ready handshake with the superpixel payload
// depends on bsd_pkg
interface bsd_rgb_if;
  import bsd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [COLOUR_BITS-1:0]    red;
  logic [GREEN_SUM_BITS-1:0] green_sum;
  logic [COLOUR_BITS-1:0]    blue;
  logic                      row_end;

  modport source (output valid, output red, output green_sum, output blue,
                  output row_end, input ready);
  modport sink   (input valid, input red, input green_sum, input blue,
                  input row_end, output ready);
endinterface

### rtl/bsd_ram.sv
// generic single-port ram with registered read
// no dependencies
module bsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and read held until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/bayer_superpixel_debayer_core.sv
// top level of the bayer superpixel debayer core
// depends on bsd_pkg, bsd_raw_if, bsd_rgb_if and bsd_ram
//
// Takes one raw sample per clock in raster order and gives one rgb pixel per
// 2x2 quad, red and blue copied, green as the sum of both green sites. The
// block sustains one sample every cycle: each sample makes at most one access
// to the line buffer, which is split into an even-column and an odd-column
// single-port ram of ceil(MAX_ROW_WIDTH/2) entries each, so both upper
// samples of a quad come out in one read. After its odd-row, odd-column
// sample is accepted, a pixel passes the middle stage and then the output
// register; these two keep input acceptance going while a pixel waits, and
// input stalls only while both hold a pixel and the output is stalled.
// The line buffer is not cleared after reset; every entry is written by the
// even row before the odd row reads it.
module bayer_superpixel_debayer_core
  #(
  parameter int MAX_ROW_WIDTH = bsd_pkg::MAX_ROW_WIDTH_DEF,
  parameter int SAMPLE_BITS   = bsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bsd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [bsd_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
  bsd_raw_if.sink                              raw_in,
  bsd_rgb_if.source                            rgb_out
);
  import bsd_pkg::*;

  localparam int CW    = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int WW    = (CW + 1 > ROW_WIDTH_BITS) ? CW + 1 : ROW_WIDTH_BITS;
  localparam int DEPTH = (MAX_ROW_WIDTH + 1) / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RESET_W = (ROW_WIDTH_RESET > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH
                                                             : ROW_WIDTH_RESET;
  localparam logic [CW-1:0] RESET_LAST      = CW'(RESET_W - 1);
  localparam logic [CW-1:0] RESET_PAIR_LAST = CW'((RESET_W / 2) * 2 - 1);

  // configuration
  cfa_pattern_t    cfa_pattern;
  logic [CW-1:0]   row_last;
  logic [CW-1:0]   pair_last;
  logic [WW-1:0]   width_raw;
  logic [WW-1:0]   width_eff;
  logic [WW-1:0]   width_even;

  // stream state
  logic [CW-1:0]          column_count;
  logic                   odd_row_flag;
  logic [SAMPLE_BITS-1:0] left_sample_hold;

  // accept-side decode
  logic                   accept;
  logic [SAMPLE_BITS-1:0] sample;
  logic [CW-1:0]          col_base;
  logic [CW-1:0]          col;
  logic                   odd_row;
  logic                   produce;
  logic [AW-1:0]          ram_addr;
  logic                   even_we;
  logic                   odd_we;
  logic                   ram_re;

  // middle stage
  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_bl;
  logic [SAMPLE_BITS-1:0] s1_br;
  logic                   s1_row_end;
  logic [SAMPLE_BITS-1:0] tl;
  logic [SAMPLE_BITS-1:0] tr;

  // output stage
  logic                   out_free;
  logic                   s1_move;
  logic [SAMPLE_BITS-1:0] r_sel;
  logic [SAMPLE_BITS-1:0] b_sel;
  logic [SAMPLE_BITS-1:0] ga_sel;
  logic [SAMPLE_BITS-1:0] gb_sel;
  logic [SAMPLE_BITS:0]   g_sum;
  logic                   out_valid;

  // clamp the written row width to the supported range
  always_comb begin
    width_raw = WW'(cfg_wdata[ROW_WIDTH_BITS-1:0]);
    width_eff = width_raw;
    if (width_raw < WW'(2)) begin
      width_eff = WW'(2);
    end else if (width_raw > WW'(MAX_ROW_WIDTH)) begin
      width_eff = WW'(MAX_ROW_WIDTH);
    end
    width_even = {width_eff[WW-1:1], 1'b0};
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfa_pattern <= PAT_RGGB;
      row_last    <= RESET_LAST;
      pair_last   <= RESET_PAIR_LAST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CFA_PATTERN) begin
        cfa_pattern <= cfa_pattern_t'(cfg_wdata[1:0]);
      end else if (cfg_index == CFG_ROW_WIDTH) begin
        row_last  <= CW'(width_eff - WW'(1));
        pair_last <= CW'(width_even - WW'(1));
      end
    end
  end

  // column and row parity of the incoming sample
  always_comb begin
    sample   = SAMPLE_BITS'(raw_in.raw_sample);
    col_base = raw_in.frame_start ? '0 : column_count;
    odd_row  = raw_in.frame_start ? 1'b0 : odd_row_flag;
    col      = (col_base > row_last) ? row_last : col_base;
    produce  = odd_row & col[0];
    ram_addr = AW'(col >> 1);
  end

  assign out_free     = !out_valid || rgb_out.ready;
  assign s1_move      = s1_valid && out_free;
  assign raw_in.ready = !s1_valid || out_free;
  assign accept       = raw_in.valid && raw_in.ready;

  assign even_we = accept && !odd_row && !col[0];
  assign odd_we  = accept && !odd_row && col[0];
  assign ram_re  = accept && produce;

  // line buffer, even and odd columns of the stored row
  bsd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_even_ram (
    .clk   (clk),
    .we    (even_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (sample),
    .rdata (tl)
  );

  bsd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_odd_ram (
    .clk   (clk),
    .we    (odd_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (sample),
    .rdata (tr)
  );

  // column counter and row parity
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      odd_row_flag <= 1'b0;
    end else if (accept) begin
      if (col >= row_last) begin
        column_count <= '0;
        odd_row_flag <= !odd_row;
      end else begin
        column_count <= col + CW'(1);
        odd_row_flag <= odd_row;
      end
    end
  end

  // lower-left sample of the quad
  always_ff @(posedge clk) begin
    if (accept && odd_row && !col[0]) begin
      left_sample_hold <= sample;
    end
  end

  // middle stage, waits for the line buffer read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (raw_in.ready) begin
      s1_valid <= accept && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s1_bl      <= left_sample_hold;
      s1_br      <= sample;
      s1_row_end <= (col == pair_last);
    end
  end

  // colour sites by layout
  always_comb begin
    case (cfa_pattern)
      PAT_BGGR: begin
        r_sel = s1_br; ga_sel = tr; gb_sel = s1_bl; b_sel = tl;
      end
      PAT_GBRG: begin
        r_sel = s1_bl; ga_sel = tl; gb_sel = s1_br; b_sel = tr;
      end
      PAT_GRBG: begin
        r_sel = tr; ga_sel = tl; gb_sel = s1_br; b_sel = s1_bl;
      end
      default: begin
        r_sel = tl; ga_sel = tr; gb_sel = s1_bl; b_sel = s1_br;
      end
    endcase
    g_sum = {1'b0, ga_sel} + {1'b0, gb_sel};
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rgb_out.red       <= COLOUR_BITS'(r_sel);
      rgb_out.green_sum <= GREEN_SUM_BITS'(g_sum);
      rgb_out.blue      <= COLOUR_BITS'(b_sel);
      rgb_out.row_end   <= s1_row_end;
    end
  end

  assign rgb_out.valid = out_valid;

endmodule

### rtl/bsd_checker.sv
// port-level checks for the bayer superpixel debayer core, bound to the top
// depends on bsd_pkg and bayer_superpixel_debayer_core_defines.svh
`include "bayer_superpixel_debayer_core_defines.svh"

module bsd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [bsd_pkg::COLOUR_BITS-1:0]     red,
  input logic [bsd_pkg::GREEN_SUM_BITS-1:0]  green_sum,
  input logic [bsd_pkg::COLOUR_BITS-1:0]     blue,
  input logic                                row_end
);
  import bsd_pkg::*;

  // a stalled pixel stays put
  `BSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable({red, green_sum, blue, row_end}),
                   "stalled pixel changed")

  // input is never blocked while the output can move
  `BSD_ASSERT_SAME(a_in_flows, !out_valid || out_ready, in_ready,
                   "input blocked with free output")

  // every new pixel comes from an input transaction through the middle stage
  `BSD_ASSERT_SAME(a_out_source, $rose(out_valid), $past(in_valid && in_ready, 2),
                   "pixel without source transaction")

  // reset empties the output
  `BSD_ASSERT_ALWAYS(a_reset_empty, rst, !out_valid, "output valid after reset")

endmodule

bind bayer_superpixel_debayer_core bsd_checker u_bsd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (raw_in.valid),
  .in_ready  (raw_in.ready),
  .out_valid (rgb_out.valid),
  .out_ready (rgb_out.ready),
  .red       (rgb_out.red),
  .green_sum (rgb_out.green_sum),
  .blue      (rgb_out.blue),
  .row_end   (rgb_out.row_end)
);
